/* rtl/ppce_pkg.sv */
// Shared types and constants for the packed pixel channel expander.
package ppce_pkg;

  localparam int PIX_W   = 16;  // packed source pixel
  localparam int CH_W    = 8;   // expanded channel
  localparam int BITS_W  = 4;   // channel width register
  localparam int OFF_W   = 6;   // channel offset, up to three widths summed
  localparam int VAL_W   = 15;  // widest extracted channel value
  localparam int X_W     = VAL_W + CH_W;  // value * 255
  localparam int RECIP_K = X_W;           // reciprocal scale, 2^RECIP_K
  localparam int RECIP_W = RECIP_K + 1;
  localparam int NUM_STG = 4;   // register stages from input to output

  localparam logic [CH_W-1:0] FULL8 = CH_W'((1 << CH_W) - 1);

  // Configuration register indexes
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_RED   = 2'd1;
  localparam logic [1:0] REG_GREEN = 2'd2;
  localparam logic [1:0] REG_BLUE  = 2'd3;

  // floor(2^RECIP_K / (2^b - 1)) for each channel width b; width zero is unused
  localparam logic [RECIP_W-1:0] RECIP [16] = '{
    RECIP_W'(0),
    RECIP_W'((64'd1 << RECIP_K) / 64'd1),
    RECIP_W'((64'd1 << RECIP_K) / 64'd3),
    RECIP_W'((64'd1 << RECIP_K) / 64'd7),
    RECIP_W'((64'd1 << RECIP_K) / 64'd15),
    RECIP_W'((64'd1 << RECIP_K) / 64'd31),
    RECIP_W'((64'd1 << RECIP_K) / 64'd63),
    RECIP_W'((64'd1 << RECIP_K) / 64'd127),
    RECIP_W'((64'd1 << RECIP_K) / 64'd255),
    RECIP_W'((64'd1 << RECIP_K) / 64'd511),
    RECIP_W'((64'd1 << RECIP_K) / 64'd1023),
    RECIP_W'((64'd1 << RECIP_K) / 64'd2047),
    RECIP_W'((64'd1 << RECIP_K) / 64'd4095),
    RECIP_W'((64'd1 << RECIP_K) / 64'd8191),
    RECIP_W'((64'd1 << RECIP_K) / 64'd16383),
    RECIP_W'((64'd1 << RECIP_K) / 64'd32767)
  };

  // Per-stage load strobes from the pipeline control to the channel lanes
  typedef struct packed {
    logic [NUM_STG-1:0] load;
  } pipe_ctl_t;

endpackage

/* rtl/packed_pixel_channel_expand.sv */
// Top level of the packed pixel channel expander.
// Throughput: one pixel per clock while out_tready holds high; four register stages
// per channel lane, each stage one narrow multiply or one add and compare, with ready
// rippling back stage by stage.
// Reset (synchronous, rst_n low): empty the pipeline and load the channel widths
// alpha 1, red 5, green 5, blue 5.
module packed_pixel_channel_expand (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [3:0]  cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] pixel
  input  logic        in_tlast,    // last_in
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic        out_tlast    // last_out
);
  import ppce_pkg::*;

  // ---------------------------------------------------------------------------
  // Channel width registers, to be written only while the pipeline is drained;
  // the block does not enforce it. Offsets are formed from the live registers.
  // ---------------------------------------------------------------------------
  logic [BITS_W-1:0] alpha_bits_r, red_bits_r, green_bits_r, blue_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_bits_r <= BITS_W'(1);
      red_bits_r   <= BITS_W'(5);
      green_bits_r <= BITS_W'(5);
      blue_bits_r  <= BITS_W'(5);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ALPHA: alpha_bits_r <= cfg_wdata;
        REG_RED:   red_bits_r   <= cfg_wdata;
        REG_GREEN: green_bits_r <= cfg_wdata;
        REG_BLUE:  blue_bits_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Channel layout: blue at bit 0, then green, red, alpha going up.
  // An offset at or past bit 16 makes the lane read zero.
  logic [OFF_W-1:0] off_g, off_r, off_a;

  assign off_g = OFF_W'(blue_bits_r);
  assign off_r = off_g + OFF_W'(green_bits_r);
  assign off_a = off_r + OFF_W'(red_bits_r);

  // ---------------------------------------------------------------------------
  // Pipeline control: one valid bit per stage, each stage refills as soon as
  // its contents move on, so bubbles close up while the output waits and the
  // input stalls only once all four stages hold work.
  // ---------------------------------------------------------------------------
  pipe_ctl_t ctl;

  ppce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_last  (out_tlast),
    .out_ready (out_tready),
    .ctl       (ctl)
  );

  // ---------------------------------------------------------------------------
  // Four identical lanes. Each scales its field by 255/(2^b - 1) with a
  // reciprocal multiply and a single-step correction. A zero-width colour
  // gives 0; a zero-width alpha gives fully opaque.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] red, green, blue, alpha;

  ppce_widen u_red (
    .clk (clk), .ctl (ctl), .pixel (in_tdata),
    .bits (red_bits_r), .offset (off_r), .zero_val ('0), .chan (red)
  );

  ppce_widen u_green (
    .clk (clk), .ctl (ctl), .pixel (in_tdata),
    .bits (green_bits_r), .offset (off_g), .zero_val ('0), .chan (green)
  );

  ppce_widen u_blue (
    .clk (clk), .ctl (ctl), .pixel (in_tdata),
    .bits (blue_bits_r), .offset ('0), .zero_val ('0), .chan (blue)
  );

  ppce_widen u_alpha (
    .clk (clk), .ctl (ctl), .pixel (in_tdata),
    .bits (alpha_bits_r), .offset (off_a), .zero_val (FULL8), .chan (alpha)
  );

  // Pack the result fields, first field in the lowest byte.
  assign out_tdata = {alpha, blue, green, red};

endmodule

/* rtl/ppce_ctrl.sv */
// Valid/ready control for the expander pipeline, with the last-pixel mark.
module ppce_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  output logic               out_last,
  input  logic               out_ready,
  output ppce_pkg::pipe_ctl_t ctl
);
  import ppce_pkg::*;

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] last_r;
  logic [NUM_STG-1:0] rdy;

  // A stage takes new data when empty or when its contents move on
  always_comb begin
    rdy[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ready;
    for (int i = NUM_STG-2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NUM_STG; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      last_r[0] <= in_last;
    end
    for (int i = 1; i < NUM_STG; i++) begin
      if (rdy[i]) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  assign ctl.load  = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STG-1];
  assign out_last  = last_r[NUM_STG-1];

endmodule

/* rtl/ppce_widen.sv */
// One channel lane: extract the field and scale it to 8 bits over four stages.
module ppce_widen (
  input  logic                            clk,
  input  ppce_pkg::pipe_ctl_t             ctl,
  input  logic [ppce_pkg::PIX_W-1:0]      pixel,
  input  logic [ppce_pkg::BITS_W-1:0]     bits,
  input  logic [ppce_pkg::OFF_W-1:0]      offset,
  input  logic [ppce_pkg::CH_W-1:0]       zero_val,
  output logic [ppce_pkg::CH_W-1:0]       chan
);
  import ppce_pkg::*;

  // Stage 1: extract value, form v*255
  logic [PIX_W-1:0]   shifted;
  logic [PIX_W-1:0]   mask;
  logic [VAL_W-1:0]   val;
  logic [X_W-1:0]     x1_r;
  logic [BITS_W-1:0]  b1_r;

  always_comb begin
    shifted = pixel >> offset[3:0];
    mask    = (PIX_W'(1) << bits) - PIX_W'(1);
    if (offset >= OFF_W'(PIX_W)) begin
      val = '0;
    end else begin
      val = VAL_W'(shifted & mask);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      x1_r <= {val, {CH_W{1'b0}}} - X_W'(val);
      b1_r <= bits;
    end
  end

  // Stage 2: quotient estimate by reciprocal, low by at most one
  logic [X_W+RECIP_W-1:0] prod;
  logic [CH_W-1:0]        q2_r;
  logic [X_W-1:0]         x2_r;
  logic [BITS_W-1:0]      b2_r;

  assign prod = (X_W+RECIP_W)'(x1_r) * (X_W+RECIP_W)'(RECIP[b1_r]);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      q2_r <= prod[RECIP_K+CH_W-1:RECIP_K];
      x2_r <= x1_r;
      b2_r <= b1_r;
    end
  end

  // Stage 3: multiply the estimate back by the divisor
  logic [VAL_W-1:0] div;
  logic [X_W-1:0]   qd3_r;
  logic [CH_W-1:0]  q3_r;
  logic [X_W-1:0]   x3_r;
  logic [VAL_W-1:0] d3_r;
  logic             zero3_r;

  assign div = VAL_W'((PIX_W'(1) << b2_r) - PIX_W'(1));

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      qd3_r   <= X_W'(q2_r) * X_W'(div);
      q3_r    <= q2_r;
      x3_r    <= x2_r;
      d3_r    <= div;
      zero3_r <= (b2_r == '0);
    end
  end

  // Stage 4: bump the estimate when the remainder reaches the divisor
  logic [X_W-1:0]  rem;
  logic [CH_W-1:0] q_fix;
  logic [CH_W-1:0] chan_r;

  always_comb begin
    rem   = x3_r - qd3_r;
    q_fix = q3_r + CH_W'(rem >= X_W'(d3_r));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      chan_r <= zero3_r ? zero_val : q_fix;
    end
  end

  assign chan = chan_r;

endmodule
